// File: hdl/range_to_prefix_split_top_macros.svh
// ---------------------------------------------------------------------------
// range_to_prefix_split_top_macros.svh
// Assertion macros shared by the range splitter RTL.
// ---------------------------------------------------------------------------
`ifndef RANGE_TO_PREFIX_SPLIT_TOP_MACROS_SVH
`define RANGE_TO_PREFIX_SPLIT_TOP_MACROS_SVH

`ifndef SYNTHESIS
// The property must hold on every clock edge outside reset.
`define RPS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("rps assertion failed");
// The condition must never be true outside reset.
`define RPS_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("rps forbidden condition seen");
`else
`define RPS_ASSERT(lbl, clk, rstn, prop)
`define RPS_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// File: hdl/rps_pkg.sv
// ---------------------------------------------------------------------------
// rps_pkg
// Widths and controller/datapath handshake types of the range splitter.
// ---------------------------------------------------------------------------
package rps_pkg;

  localparam int unsigned AddrBits = 32;
  localparam int unsigned KBits    = $clog2(AddrBits + 2);
  localparam int unsigned LenBits  = 6;

  typedef logic [AddrBits-1:0] addr_t;
  typedef logic [AddrBits:0]   wide_t;
  typedef logic [KBits-1:0]    kexp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic emit;
    logic k_inc;
    logic k_dec;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic bit_set;
    logic fits;
    logic rem_bit;
    logic last;
    logic out_free;
  } status_t;

endpackage

// File: hdl/rps_range_if.sv
// ---------------------------------------------------------------------------
// rps_range_if / rps_block_if
// Valid/ready channels for input ranges and output prefix blocks.
// ---------------------------------------------------------------------------
interface rps_range_if import rps_pkg::*; ();
  logic  valid;
  logic  ready;
  addr_t range_start;
  addr_t range_end;

  modport source (output valid, output range_start, output range_end, input ready);
  modport sink   (input valid, input range_start, input range_end, output ready);
endinterface

interface rps_block_if import rps_pkg::*; ();
  logic               valid;
  logic               ready;
  addr_t              block_base;
  logic [LenBits-1:0] block_prefix_len;
  logic               last_block;

  modport source (output valid, output block_base, output block_prefix_len,
                  output last_block, input ready);
  modport sink   (input valid, input block_base, input block_prefix_len,
                  input last_block, output ready);
endinterface

// File: hdl/rps_datapath.sv
// ---------------------------------------------------------------------------
// rps_datapath
// Current address, remaining length, block exponent and output register.
// ---------------------------------------------------------------------------
`include "range_to_prefix_split_top_macros.svh"

module rps_datapath import rps_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  addr_t              range_start_i,
  input  addr_t              range_end_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output addr_t              block_base_o,
  output logic [LenBits-1:0] block_prefix_len_o,
  output logic               last_block_o
);

  addr_t cur_q, cur_d;
  wide_t rem_q, rem_d;
  kexp_t k_q, k_d;
  wide_t size;

  logic               out_valid_q, out_valid_d;
  addr_t              base_q;
  logic [LenBits-1:0] len_q;
  logic               last_q;

  assign size = wide_t'(1) << k_q;

  always_comb begin
    status_o.empty    = range_start_i > range_end_i;
    status_o.bit_set  = (k_q == kexp_t'(AddrBits)) ||
                        cur_q[k_q[$clog2(AddrBits)-1:0]];
    status_o.fits     = size <= rem_q;
    status_o.rem_bit  = rem_q[k_q];
    status_o.last     = size == rem_q;
    status_o.out_free = !out_valid_q || out_ready_i;
  end

  always_comb begin
    cur_d = cur_q;
    rem_d = rem_q;
    k_d   = k_q;
    if (cmd_i.load) begin
      cur_d = range_start_i;
      rem_d = {1'b0, range_end_i} - {1'b0, range_start_i} + wide_t'(1);
      k_d   = '0;
    end else begin
      if (cmd_i.emit) begin
        cur_d = cur_q + size[AddrBits-1:0];
        rem_d = rem_q - size;
      end
      if (cmd_i.k_inc) begin
        k_d = k_q + kexp_t'(1);
      end else if (cmd_i.k_dec) begin
        k_d = k_q - kexp_t'(1);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    rem_q <= rem_d;
    k_q   <= k_d;
    if (cmd_i.emit) begin
      base_q <= cur_q;
      len_q  <= LenBits'(AddrBits) - LenBits'(k_q);
      last_q <= size == rem_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign block_base_o       = base_q;
  assign block_prefix_len_o = len_q;
  assign last_block_o       = last_q;

  // A block that goes out must fit in what is left and be aligned at its base.
  `RPS_ASSERT(a_emit_fits, clk_i, rst_ni, cmd_i.emit |-> size <= rem_q)
  `RPS_ASSERT(a_emit_aligned, clk_i, rst_ni,
              cmd_i.emit |-> ({1'b0, cur_q} & (size - wide_t'(1))) == '0)
  `RPS_NEVER(a_emit_overwrite, clk_i, rst_ni, cmd_i.emit && out_valid_q && !out_ready_i)
  `RPS_ASSERT(a_load_nonempty, clk_i, rst_ni,
              cmd_i.load && !status_o.empty |=> rem_q != '0)

endmodule

// File: hdl/rps_ctrl.sv
// ---------------------------------------------------------------------------
// rps_ctrl
// Walks the block exponent up while the start is aligned, then down
// through the set bits of the remaining length.
// ---------------------------------------------------------------------------
`include "range_to_prefix_split_top_macros.svh"

module rps_ctrl import rps_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StAsc  = 2'd1;
  localparam logic [1:0] StDesc = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (!status_i.empty) begin
            state_d = StAsc;
          end
        end
      end
      StAsc: begin
        if (status_i.bit_set) begin
          if (status_i.fits) begin
            if (status_i.out_free) begin
              cmd_o.emit  = 1'b1;
              cmd_o.k_inc = 1'b1;
              if (status_i.last) begin
                state_d = StIdle;
              end
            end
          end else begin
            // The aligned block overruns the end: sizes only shrink from here.
            cmd_o.k_dec = 1'b1;
            state_d     = StDesc;
          end
        end else begin
          cmd_o.k_inc = 1'b1;
        end
      end
      StDesc: begin
        if (status_i.rem_bit) begin
          if (status_i.out_free) begin
            cmd_o.emit  = 1'b1;
            cmd_o.k_dec = 1'b1;
            if (status_i.last) begin
              state_d = StIdle;
            end
          end
        end else begin
          cmd_o.k_dec = 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  `RPS_ASSERT(a_last_ends, clk_i, rst_ni,
              cmd_o.emit && status_i.last |=> state_q == StIdle)
  `RPS_NEVER(a_load_busy, clk_i, rst_ni, cmd_o.load && state_q != StIdle)
  `RPS_ASSERT(a_empty_stays, clk_i, rst_ni,
              cmd_o.load && status_i.empty |=> state_q == StIdle)

endmodule

// File: hdl/range_to_prefix_split_top.sv
// Range splitter: one inclusive range in, its minimal aligned prefix blocks out.
// Operation: the range is loaded, then the block-size exponent
// walks up from 0 and back down.
// Throughput: one range at a time, at most one block per cycle, plus output stalls.
// Reset: asynchronous, active low; clears the controller and the output valid.
// ---------------------------------------------------------------------------
// range_to_prefix_split_top
// Top level: controller and datapath joined by command and status structs.
// ---------------------------------------------------------------------------
module range_to_prefix_split_top import rps_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  rps_range_if.sink     range_i,
  rps_block_if.source   block_o
);

  cmd_t    cmd;
  status_t status;

  rps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (range_i.valid),
    .in_ready_o (range_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rps_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .range_start_i      (range_i.range_start),
    .range_end_i        (range_i.range_end),
    .out_valid_o        (block_o.valid),
    .out_ready_i        (block_o.ready),
    .block_base_o       (block_o.block_base),
    .block_prefix_len_o (block_o.block_prefix_len),
    .last_block_o       (block_o.last_block)
  );

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for range_to_prefix_split_top: drives inclusive address
// ranges, predicts the aligned prefix blocks of each one and checks every
// block beat in order, with random idle bursts on both channels.
// ---------------------------------------------------------------------------
module tb;
  import rps_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned DrainWait  = 2 * AddrBits + 8;

  typedef struct packed {
    addr_t              base;
    logic [LenBits-1:0] plen;
    logic               last;
  } prefix_blk_t;

  logic clk;
  logic rst_n;

  rps_range_if range_if ();
  rps_block_if block_if ();

  range_to_prefix_split_top DUT (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .range_i (range_if),
    .block_o (block_if)
  );

  prefix_blk_t pending_blocks[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned stall_left;
  bit          sender_idle_en;
  bit          sink_idle_en;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Greedy split: at each step take the largest block aligned at the current
  // address that still ends at or before the range end. One spare bit keeps
  // address 0 (a /0 block) and ranges ending at the top address well defined.
  function automatic void split_range(input addr_t first, input addr_t final_addr);
    wide_t       cur;
    wide_t       lim;
    wide_t       top;
    int unsigned k;
    bit          done;
    prefix_blk_t blk;
    cur = {1'b0, first};
    lim = {1'b0, final_addr};
    if (cur > lim) return;
    done = 1'b0;
    while (!done) begin
      k = 0;
      while (k < AddrBits && cur[k] == 1'b0) k++;
      while (k > 0 && cur + ((wide_t'(1) << k) - 1) > lim) k--;
      top       = cur + ((wide_t'(1) << k) - 1);
      done      = (top == lim);
      blk.base  = cur[AddrBits-1:0];
      blk.plen  = LenBits'(AddrBits - k);
      blk.last  = done;
      pending_blocks.push_back(blk);
      cur = top + 1;
    end
  endfunction

  // Sends one range and leaves valid high; it drops only on an idle burst, before
  // the drain pause or at the end of the run.
  task automatic send_range(input addr_t first, input addr_t final_addr);
    int unsigned gap;
    if (sender_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      range_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    range_if.valid       <= 1'b1;
    range_if.range_start <= first;
    range_if.range_end   <= final_addr;
    do @(posedge clk); while (!range_if.ready);
    split_range(first, final_addr);
  endtask

  task automatic wait_all_blocks();
    while (pending_blocks.size() != 0) @(posedge clk);
  endtask

  task automatic make_range(output addr_t first, output addr_t final_addr);
    wide_t       mask;
    int unsigned k;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    first      = $urandom;
    final_addr = $urandom;
    if (pick < 45) begin
      if (first > final_addr) {first, final_addr} = {final_addr, first};
    end else if (pick < 60) begin
      final_addr = first + $urandom_range(0, 300);
      if (final_addr < first) final_addr = '1;
    end else if (pick < 72) begin
      k          = $urandom_range(0, AddrBits);
      mask       = (wide_t'(1) << k) - 1;
      first      = first & ~mask[AddrBits-1:0];
      final_addr = first | mask[AddrBits-1:0];
    end else if (pick < 82) begin
      final_addr = '1;
    end else if (pick < 88) begin
      first = '0;
    end else begin
      // Start above end: the block must stay silent.
      if (first < final_addr) {first, final_addr} = {final_addr, first};
      if (first == final_addr) begin
        if (final_addr != '0) final_addr = final_addr - addr_t'(1);
        else first = addr_t'(1);
      end
    end
  endtask

  task automatic run_random(input int unsigned count);
    addr_t       first;
    addr_t       final_addr;
    int unsigned sent;
    sent = 0;
    while (sent < count) begin
      make_range(first, final_addr);
      send_range(first, final_addr);
      sent++;
    end
  endtask

  task automatic test_edge_ranges();
    send_range(32'h0000_0000, 32'hFFFF_FFFF);
    send_range(32'h0000_0000, 32'h0000_0000);
    send_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_range(32'h0000_0001, 32'hFFFF_FFFE);
    send_range(32'h0000_0005, 32'h0000_0004);
    send_range(32'hFFFF_FFFF, 32'h0000_0000);
    send_range(32'h0000_0000, 32'h7FFF_FFFF);
    send_range(32'h8000_0000, 32'hFFFF_FFFF);
    send_range(32'h0000_0001, 32'hFFFF_FFFF);
    send_range(32'h0000_0000, 32'hFFFF_FFFE);
    send_range(32'h0000_0010, 32'h0000_001F);
    send_range(32'hAAAA_AAAA, 32'h5555_5555);
    send_range(32'h5555_5555, 32'hAAAA_AAAA);
    send_range(32'h1234_5678, 32'h1234_5678);
    send_range(32'hFFFF_FF00, 32'hFFFF_FFFF);
    send_range(32'h0000_0000, 32'h0000_00FF);
  endtask

  task automatic test_random_ranges();
    run_random(80);
  endtask

  // The sender holds off until the block has emitted every pending beat.
  task automatic test_drain_pause();
    run_random(8);
    range_if.valid <= 1'b0;
    @(posedge clk);
    wait_all_blocks();
    run_random(8);
  endtask

  task automatic test_full_rate();
    sender_idle_en = 1'b0;
    sink_idle_en   = 1'b0;
    run_random(60);
  endtask

  // Block channel: random ready stalls and in-order checking of every beat.
  always @(posedge clk) begin
    prefix_blk_t want;
    if (rst_n) begin
      if (block_if.valid && block_if.ready) begin
        if (pending_blocks.size() == 0) begin
          report_mismatch($sformatf("unexpected block base=%h len=%0d last=%0b",
                          block_if.block_base, block_if.block_prefix_len,
                          block_if.last_block));
        end else begin
          want = pending_blocks.pop_front();
          if (block_if.block_base !== want.base)
            report_mismatch($sformatf("block_base %h, want %h",
                            block_if.block_base, want.base));
          if (block_if.block_prefix_len !== want.plen)
            report_mismatch($sformatf("block_prefix_len %0d, want %0d (base %h)",
                            block_if.block_prefix_len, want.plen, want.base));
          if (block_if.last_block !== want.last)
            report_mismatch($sformatf("last_block %0b, want %0b (base %h)",
                            block_if.last_block, want.last, want.base));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        block_if.ready <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 16);
        block_if.ready <= 1'b0;
      end else begin
        block_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    clk                  = 1'b0;
    rst_n                = 1'b0;
    range_if.valid       = 1'b0;
    range_if.range_start = '0;
    range_if.range_end   = '0;
    block_if.ready       = 1'b0;
    mismatch_count       = 0;
    cycle_count          = 0;
    stall_left           = 0;
    sender_idle_en       = 1'b1;
    sink_idle_en         = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_edge_ranges();
    test_random_ranges();
    test_drain_pause();
    test_full_rate();

    range_if.valid <= 1'b0;
    @(posedge clk);
    wait_all_blocks();
    repeat (DrainWait) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
